// ----- src/prr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_pkg
// Shared widths, constants and types of the pseudorange residual unit.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int POS_FRAC_BITS = 10;
    localparam int DIR_FRAC_BITS = 30;

    localparam int POS_W   = 40;               // coordinate / range fields
    localparam int DIFF_W  = POS_W + 1;        // signed coordinate difference
    localparam int SQ_W    = 2 * POS_W;        // one squared magnitude
    localparam int SUM_W   = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W  = POS_W + 1;        // floor square root
    localparam int RANGE_W = ROOT_W + 1;       // rounded range
    localparam int PRE_W   = POS_W + 2;        // bias minus measured
    localparam int RES_W   = RANGE_W + 2;      // unsaturated residual
    localparam int DIR_W   = 32;
    localparam int Q_W     = 32;               // quotient bits per lane
    localparam int NUM_SH  = DIR_FRAC_BITS + 1;
    localparam int NUM_W   = POS_W + NUM_SH + 1;
    localparam int DEN_W   = RANGE_W + 1;
    localparam int CMP_W   = DEN_W + Q_W;
    localparam int SQ_STAGES = ROOT_W;
    localparam int LO_W    = 32;
    localparam int HI_W    = POS_W - LO_W;

    localparam logic [7:0] GPS_MAX      = 8'd32;
    localparam logic [7:0] GPS_EXTRA    = 8'd84;
    localparam logic [7:0] BEIDOU_MIN   = 8'd87;
    localparam logic [7:0] BEIDOU_MAX   = 8'd121;

    localparam logic CLK_GPS    = 1'b0;
    localparam logic CLK_BEIDOU = 1'b1;

    typedef logic [POS_W-1:0] mag_t;
    typedef mag_t [2:0]       mag3_t;

    // Per-transaction sideband carried alongside the arithmetic
    typedef struct packed {
        logic                    sys;
        logic                    bad;
        logic                    zero;
        logic [2:0]              pos;   // difference component strictly positive
        logic signed [PRE_W-1:0] pre;   // residual before adding the range
    } side_t;

endpackage

// ----- src/pseudorange_residual_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudorange_residual_unit_core
// GNSS pseudorange residual with negated unit line-of-sight vector.
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_valid / s_ready  | positions, biases, number, range
//  m_       | out       | m_valid / m_ready  | residual, dir_x/y/z, flags
//
// Pipeline: 4 front stages, 41 square root stages plus rounding, 33 divider
// stages and the output register. One transaction per cycle while the output is not stalled.
// Reset (aresetn low, synchronous) clears all valid bits.
// A result not taken stalls the whole pipeline; s_ready drops with it.
// ----------------------------------------------------------------------------
module pseudorange_residual_unit_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [prr_pkg::POS_W-1:0] s_sat_x,
    input  logic signed [prr_pkg::POS_W-1:0] s_sat_y,
    input  logic signed [prr_pkg::POS_W-1:0] s_sat_z,
    input  logic signed [prr_pkg::POS_W-1:0] s_rx_x,
    input  logic signed [prr_pkg::POS_W-1:0] s_rx_y,
    input  logic signed [prr_pkg::POS_W-1:0] s_rx_z,
    input  logic signed [prr_pkg::POS_W-1:0] s_bias_gps,
    input  logic signed [prr_pkg::POS_W-1:0] s_bias_beidou,
    input  logic        [7:0]                s_sat_number,
    input  logic signed [prr_pkg::POS_W-1:0] s_measured_range,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [prr_pkg::POS_W-1:0] m_residual,
    output logic signed [prr_pkg::DIR_W-1:0] m_dir_x,
    output logic signed [prr_pkg::DIR_W-1:0] m_dir_y,
    output logic signed [prr_pkg::DIR_W-1:0] m_dir_z,
    output logic                             m_clock_system,
    output logic                             m_bad_number,
    output logic                             m_zero_range
);

    localparam logic [prr_pkg::Q_W-1:0] DIR_ONE = prr_pkg::Q_W'(1) << prr_pkg::DIR_FRAC_BITS;
    localparam logic signed [prr_pkg::RES_W-1:0] RES_MAX =
        prr_pkg::RES_W'({1'b0, {(prr_pkg::POS_W-1){1'b1}}});
    localparam logic signed [prr_pkg::RES_W-1:0] RES_MIN = -RES_MAX - prr_pkg::RES_W'(1);

    logic                        en;
    logic                        f_valid, q_valid, d_valid;
    logic [prr_pkg::SUM_W-1:0]   f_sum;
    prr_pkg::mag3_t              f_mag, q_mag;
    prr_pkg::side_t              f_side, q_side, d_side;
    logic [prr_pkg::RANGE_W-1:0] q_range, d_range;
    logic [prr_pkg::Q_W-1:0]     d_quot [3];

    logic signed [prr_pkg::RES_W-1:0] res_full;
    logic signed [prr_pkg::POS_W-1:0] res_next;
    logic signed [prr_pkg::DIR_W-1:0] dir_next [3];
    logic [prr_pkg::Q_W-1:0]          qc;

    logic                             m_valid_reg;
    logic signed [prr_pkg::POS_W-1:0] residual_reg;
    logic signed [prr_pkg::DIR_W-1:0] dir_reg [3];
    logic                             sys_reg, bad_reg, zero_reg;

    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;

    prr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .sat_x          (s_sat_x),
        .sat_y          (s_sat_y),
        .sat_z          (s_sat_z),
        .rx_x           (s_rx_x),
        .rx_y           (s_rx_y),
        .rx_z           (s_rx_z),
        .bias_gps       (s_bias_gps),
        .bias_beidou    (s_bias_beidou),
        .sat_number     (s_sat_number),
        .measured_range (s_measured_range),
        .out_valid      (f_valid),
        .sum            (f_sum),
        .mag            (f_mag),
        .side           (f_side)
    );

    prr_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .sum       (f_sum),
        .mag_in    (f_mag),
        .side_in   (f_side),
        .out_valid (q_valid),
        .range     (q_range),
        .mag_out   (q_mag),
        .side_out  (q_side)
    );

    prr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .range_in  (q_range),
        .mag_in    (q_mag),
        .side_in   (q_side),
        .out_valid (d_valid),
        .range_out (d_range),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    always_comb begin
        res_full = prr_pkg::RES_W'(d_side.pre)
                 + (d_side.bad ? '0 : prr_pkg::RES_W'({1'b0, d_range}));
        if (res_full > RES_MAX)
            res_next = prr_pkg::POS_W'(RES_MAX);
        else if (res_full < RES_MIN)
            res_next = prr_pkg::POS_W'(RES_MIN);
        else
            res_next = prr_pkg::POS_W'(res_full);
        qc = '0;
        for (int k = 0; k < 3; k++) begin
            qc = (d_quot[k] > DIR_ONE) ? DIR_ONE : d_quot[k];
            if (d_side.zero)
                dir_next[k] = '0;
            else if (d_side.pos[k])
                dir_next[k] = -prr_pkg::DIR_W'(qc);
            else
                dir_next[k] = prr_pkg::DIR_W'(qc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            residual_reg <= res_next;
            dir_reg      <= dir_next;
            sys_reg      <= d_side.sys;
            bad_reg      <= d_side.bad;
            zero_reg     <= d_side.zero;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_residual     = residual_reg;
    assign m_dir_x        = dir_reg[0];
    assign m_dir_y        = dir_reg[1];
    assign m_dir_z        = dir_reg[2];
    assign m_clock_system = sys_reg;
    assign m_bad_number   = bad_reg;
    assign m_zero_range   = zero_reg;

endmodule

// ----- src/prr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_front
// Differences, constellation decode and sum of squares (four stages).
// Squares are built from 32x32, 8x32 and 8x8 partial products.
// ----------------------------------------------------------------------------
module prr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [prr_pkg::POS_W-1:0] sat_x,
    input  logic signed [prr_pkg::POS_W-1:0] sat_y,
    input  logic signed [prr_pkg::POS_W-1:0] sat_z,
    input  logic signed [prr_pkg::POS_W-1:0] rx_x,
    input  logic signed [prr_pkg::POS_W-1:0] rx_y,
    input  logic signed [prr_pkg::POS_W-1:0] rx_z,
    input  logic signed [prr_pkg::POS_W-1:0] bias_gps,
    input  logic signed [prr_pkg::POS_W-1:0] bias_beidou,
    input  logic        [7:0]               sat_number,
    input  logic signed [prr_pkg::POS_W-1:0] measured_range,
    output logic                            out_valid,
    output logic [prr_pkg::SUM_W-1:0]       sum,
    output prr_pkg::mag3_t                  mag,
    output prr_pkg::side_t                  side
);

    logic signed [prr_pkg::DIFF_W-1:0] d_next [3];
    prr_pkg::mag3_t                    mag_next;
    prr_pkg::side_t                    side_next;
    logic                              is_gps, is_bd;
    logic signed [prr_pkg::PRE_W-1:0]  meas_ext;

    logic [3:0]     valid_reg;
    prr_pkg::mag3_t mag1_reg, mag2_reg, mag3_reg, mag4_reg;
    prr_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg;
    prr_pkg::side_t side4_next;

    logic [2*prr_pkg::LO_W-1:0]           pp_ll_reg [3];
    logic [prr_pkg::HI_W+prr_pkg::LO_W-1:0] pp_hl_reg [3];
    logic [2*prr_pkg::HI_W-1:0]           pp_hh_reg [3];
    logic [prr_pkg::SQ_W-1:0]             sq_reg [3];
    logic [prr_pkg::SUM_W-1:0]            sum_reg;
    logic                                 zero_next;

    always_comb begin
        d_next[0] = prr_pkg::DIFF_W'(sat_x) - prr_pkg::DIFF_W'(rx_x);
        d_next[1] = prr_pkg::DIFF_W'(sat_y) - prr_pkg::DIFF_W'(rx_y);
        d_next[2] = prr_pkg::DIFF_W'(sat_z) - prr_pkg::DIFF_W'(rx_z);
        for (int k = 0; k < 3; k++) begin
            mag_next[k] = d_next[k][prr_pkg::DIFF_W-1]
                        ? prr_pkg::POS_W'(-d_next[k]) : prr_pkg::POS_W'(d_next[k]);
            side_next.pos[k] = ~d_next[k][prr_pkg::DIFF_W-1] && (d_next[k] != '0);
        end
        is_gps = (sat_number <= prr_pkg::GPS_MAX) || (sat_number == prr_pkg::GPS_EXTRA);
        is_bd  = (sat_number >= prr_pkg::BEIDOU_MIN) && (sat_number <= prr_pkg::BEIDOU_MAX);
        meas_ext       = prr_pkg::PRE_W'(measured_range);
        side_next.sys  = is_gps ? prr_pkg::CLK_GPS : (is_bd ? prr_pkg::CLK_BEIDOU
                                                            : prr_pkg::CLK_GPS);
        side_next.bad  = ~is_gps & ~is_bd;
        side_next.zero = 1'b0;
        if (is_gps)
            side_next.pre = prr_pkg::PRE_W'(bias_gps) - meas_ext;
        else if (is_bd)
            side_next.pre = prr_pkg::PRE_W'(bias_beidou) - meas_ext;
        else
            side_next.pre = -meas_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    assign zero_next = (sq_reg[0] == '0) && (sq_reg[1] == '0) && (sq_reg[2] == '0);

    always_comb begin
        side4_next      = side3_reg;
        side4_next.zero = zero_next;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag_next;
            side1_reg <= side_next;
            for (int k = 0; k < 3; k++) begin
                pp_ll_reg[k] <= mag1_reg[k][prr_pkg::LO_W-1:0] * mag1_reg[k][prr_pkg::LO_W-1:0];
                pp_hl_reg[k] <= mag1_reg[k][prr_pkg::POS_W-1:prr_pkg::LO_W]
                              * mag1_reg[k][prr_pkg::LO_W-1:0];
                pp_hh_reg[k] <= mag1_reg[k][prr_pkg::POS_W-1:prr_pkg::LO_W]
                              * mag1_reg[k][prr_pkg::POS_W-1:prr_pkg::LO_W];
                sq_reg[k] <= prr_pkg::SQ_W'(pp_ll_reg[k])
                           + (prr_pkg::SQ_W'(pp_hl_reg[k]) << (prr_pkg::LO_W + 1))
                           + (prr_pkg::SQ_W'(pp_hh_reg[k]) << (2 * prr_pkg::LO_W));
            end
            mag2_reg  <= mag1_reg;
            side2_reg <= side1_reg;
            mag3_reg  <= mag2_reg;
            side3_reg <= side2_reg;
            sum_reg   <= prr_pkg::SUM_W'(sq_reg[0]) + prr_pkg::SUM_W'(sq_reg[1])
                       + prr_pkg::SUM_W'(sq_reg[2]);
            mag4_reg  <= mag3_reg;
            side4_reg <= side4_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign sum       = sum_reg;
    assign mag       = mag4_reg;
    assign side      = side4_reg;

endmodule

// ----- src/prr_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_sqrt
// Pipelined digit-by-digit square root, one result bit per stage,
// followed by a round-to-nearest stage.
// ----------------------------------------------------------------------------
module prr_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [prr_pkg::SUM_W-1:0]     sum,
    input  prr_pkg::mag3_t                mag_in,
    input  prr_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [prr_pkg::RANGE_W-1:0]   range,
    output prr_pkg::mag3_t                mag_out,
    output prr_pkg::side_t                side_out
);

    localparam int NS = prr_pkg::SQ_STAGES;

    logic [NS-1:0]               valid_reg;
    logic [prr_pkg::SUM_W-1:0]   rem_reg  [NS];
    logic [prr_pkg::ROOT_W-1:0]  res_reg  [NS];
    prr_pkg::mag3_t              mag_reg  [NS];
    prr_pkg::side_t              side_reg [NS];

    logic                        vout_reg;
    logic [prr_pkg::RANGE_W-1:0] range_reg;
    prr_pkg::mag3_t              mago_reg;
    prr_pkg::side_t              sideo_reg;

    for (genvar j = 0; j < NS; j++) begin : g_st
        localparam int B = NS - 1 - j;
        logic                       v_in;
        logic [prr_pkg::SUM_W-1:0]  rem_in, trial;
        logic [prr_pkg::ROOT_W-1:0] res_in;
        prr_pkg::mag3_t             m_in;
        prr_pkg::side_t             s_in;

        if (j == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = sum;
            assign res_in = '0;
            assign m_in   = mag_in;
            assign s_in   = side_in;
        end else begin : g_next
            assign v_in   = valid_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
            assign m_in   = mag_reg[j-1];
            assign s_in   = side_reg[j-1];
        end

        // (2*res + 2^B) * 2^B with the low bits of res still clear
        assign trial = (prr_pkg::SUM_W'(res_in) << (B + 1))
                     | (prr_pkg::SUM_W'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    rem_reg[j] <= rem_in - trial;
                    res_reg[j] <= res_in | (prr_pkg::ROOT_W'(1) << B);
                end else begin
                    rem_reg[j] <= rem_in;
                    res_reg[j] <= res_in;
                end
                mag_reg[j]  <= m_in;
                side_reg[j] <= s_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
        end else if (en) begin
            vout_reg <= valid_reg[NS-1];
        end
    end

    // round up when remainder exceeds the root
    always_ff @(posedge aclk) begin
        if (en) begin
            range_reg <= prr_pkg::RANGE_W'(res_reg[NS-1])
                       + prr_pkg::RANGE_W'(rem_reg[NS-1] > prr_pkg::SUM_W'(res_reg[NS-1]));
            mago_reg  <= mag_reg[NS-1];
            sideo_reg <= side_reg[NS-1];
        end
    end

    assign out_valid = vout_reg;
    assign range     = range_reg;
    assign mag_out   = mago_reg;
    assign side_out  = sideo_reg;

endmodule

// ----- src/prr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prr_div
// Three-lane pipelined restoring divider, one quotient bit per stage:
// q = floor((mag * 2^(F+1) + r) / (2r)), i.e. mag * 2^F / r rounded.
// ----------------------------------------------------------------------------
module prr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [prr_pkg::RANGE_W-1:0]   range_in,
    input  prr_pkg::mag3_t                mag_in,
    input  prr_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [prr_pkg::RANGE_W-1:0]   range_out,
    output logic [prr_pkg::Q_W-1:0]       quot [3],
    output prr_pkg::side_t                side_out
);

    localparam int NS = prr_pkg::Q_W;

    logic                        v0_reg;
    logic [prr_pkg::NUM_W-1:0]   num0_reg [3];
    logic [prr_pkg::DEN_W-1:0]   den0_reg;
    logic [prr_pkg::RANGE_W-1:0] r0_reg;
    prr_pkg::side_t              side0_reg;

    logic [NS-1:0]               valid_reg;
    logic [prr_pkg::NUM_W-1:0]   rem_reg  [NS][3];
    logic [prr_pkg::Q_W-1:0]     q_reg    [NS][3];
    logic [prr_pkg::DEN_W-1:0]   den_reg  [NS];
    logic [prr_pkg::RANGE_W-1:0] r_reg    [NS];
    prr_pkg::side_t              side_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num0_reg[k] <= (prr_pkg::NUM_W'(mag_in[k]) << prr_pkg::NUM_SH)
                             + prr_pkg::NUM_W'(range_in);
            end
            den0_reg  <= {range_in, 1'b0};
            r0_reg    <= range_in;
            side0_reg <= side_in;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_st
        localparam int I = NS - 1 - j;
        logic                        v_in;
        logic [prr_pkg::NUM_W-1:0]   rem_in [3];
        logic [prr_pkg::Q_W-1:0]     q_in   [3];
        logic [prr_pkg::DEN_W-1:0]   den_in;
        logic [prr_pkg::RANGE_W-1:0] r_in;
        prr_pkg::side_t              s_in;
        logic [prr_pkg::CMP_W-1:0]   dsh;

        if (j == 0) begin : g_first
            assign v_in   = v0_reg;
            assign rem_in = num0_reg;
            assign q_in   = '{default: '0};
            assign den_in = den0_reg;
            assign r_in   = r0_reg;
            assign s_in   = side0_reg;
        end else begin : g_next
            assign v_in   = valid_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign den_in = den_reg[j-1];
            assign r_in   = r_reg[j-1];
            assign s_in   = side_reg[j-1];
        end

        assign dsh = prr_pkg::CMP_W'(den_in) << I;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (en) begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    if (prr_pkg::CMP_W'(rem_in[k]) >= dsh) begin
                        rem_reg[j][k] <= prr_pkg::NUM_W'(prr_pkg::CMP_W'(rem_in[k]) - dsh);
                        q_reg[j][k]   <= q_in[k] | (prr_pkg::Q_W'(1) << I);
                    end else begin
                        rem_reg[j][k] <= rem_in[k];
                        q_reg[j][k]   <= q_in[k];
                    end
                end
                den_reg[j]  <= den_in;
                r_reg[j]    <= r_in;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign range_out = r_reg[NS-1];
    assign quot      = q_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule
